// ===== hw/rtl/oepf_pkg.sv =====
// ----------------------------------------------------------------------------
// oepf_pkg
// Shared types and constants of the one euro point filter: unit widths,
// register indexes, fixed-point constants, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package oepf_pkg;

    localparam int MUL_W       = 33;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int DIV_W       = 64;
    localparam int CNT_W       = 7;
    localparam int ROOT_W      = 32;
    localparam int SQ_STEPS    = 32;
    localparam int ALPHA_W     = 17;
    localparam int ALPHA_STEPS = 17;

    localparam logic [31:0]        TWO_PI_Q29  = 32'd3373259426;
    localparam logic [31:0]        STEP_FLOOR  = 32'd16;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;
    localparam logic [DIV_W-1:0]   P_CAP       = 64'h4000_0000_0000_0000;
    localparam logic [DIV_W-1:0]   P_ONE       = 64'h0000_0001_0000_0000;
    localparam logic [DIV_W-1:0]   N_ONE       = 64'h0001_0000_0000_0000;
    localparam logic [DIV_W-1:0]   SQ_TOP_BIT  = 64'h4000_0000_0000_0000;

    localparam logic [31:0] MIN_CUT_RST = 32'd65536;
    localparam logic [31:0] BETA_RST    = 32'd0;
    localparam logic [31:0] DCUT_RST    = 32'd65536;
    localparam logic [31:0] STEP_RST    = 32'd559241;

    typedef enum logic [1:0] {
        REG_MIN_CUTOFF   = 2'd0,
        REG_BETA_GAIN    = 2'd1,
        REG_DERIV_CUTOFF = 2'd2,
        REG_DEFAULT_STEP = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] steps;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_ALPHA = 11'b000_0000_0010,
        S_ADIV  = 11'b000_0000_0100,
        S_RATE  = 11'b000_0000_1000,
        S_RDIV  = 11'b000_0001_0000,
        S_BLEND = 11'b000_0010_0000,
        S_SHIFT = 11'b000_0100_0000,
        S_SQ    = 11'b000_1000_0000,
        S_SQRT  = 11'b001_0000_0000,
        S_CUT   = 11'b010_0000_0000,
        S_OUT   = 11'b100_0000_0000
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/one_euro_point_filter_top.sv =====
// ----------------------------------------------------------------------------
// one_euro_point_filter_top
// One Euro adaptive low-pass filter for a 2D point in fixed point, run by a
// sequencer over one shared multiplier, a serial divider and a serial root.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_stall   i_cmd i_x_in i_y_in i_step_time
//   out      output     o_out_valid / i_out_stall o_x_out o_y_out
//   cfg      input      i_cfg_we                  i_cfg_idx i_cfg_data
//
// The divider yields one quotient bit per cycle for two alpha and up to two
// rate divisions, and the root unit one bit per cycle. A shift step comes
// before the root when the rates need it, and the beta product is skipped
// with a zero beta gain.
// Input stalls while a sample is in work; the output register lets the next
// sample enter while a result waits. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
`default_nettype none

module one_euro_point_filter_top import oepf_pkg::*; #(
    parameter int COORD_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_cmd,
    input  wire logic [31:0] i_x_in,
    input  wire logic [31:0] i_y_in,
    input  wire logic [31:0] i_step_time,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [31:0] o_x_out,
    output logic      [31:0] o_y_out,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

    localparam int CW   = COORD_BITS;
    localparam int MW   = CW + 1;
    localparam int EW   = (CW > 32) ? CW : 32;
    localparam int SW   = (MW > 32) ? MW : 32;
    localparam int HW   = SW - 16;
    localparam int SH_W = $clog2(SW);

    localparam logic signed [CW-1:0] C_HI   = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_LO   = {1'b1, {(CW-1){1'b0}}};
    localparam logic        [CW-1:0] C_HALF = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [31:0]   O_HI   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0]   O_LO   = 32'sh8000_0000;

    // control
    t_state r_state, n_state;
    logic [2:0] r_ph, n_ph;
    logic r_lane, n_lane, r_pass, n_pass, r_seeded, n_seeded, r_ovalid, n_ovalid;
    logic [31:0] r_min_cut, r_beta, r_dcut, r_dstep;
    logic signed [CW-1:0] r_last_x, n_last_x, r_last_y, n_last_y;
    logic signed [CW-1:0] r_rate_x, n_rate_x, r_rate_y, n_rate_y;

    // datapath
    logic signed [CW-1:0] r_px, n_px, r_py, n_py, r_raw, n_raw;
    logic [31:0] r_dt, n_dt, r_fc, n_fc, r_ox, n_ox, r_oy, n_oy;
    logic [DIV_W-1:0] r_u, n_u, r_acc, n_acc;
    logic [ALPHA_W-1:0] r_alpha, n_alpha;
    logic [MW-1:0] r_mag, n_mag;
    logic r_neg, n_neg;
    logic [CW-1:0] r_sa, n_sa, r_sb, n_sb;
    logic [SH_W-1:0] r_s, n_s;
    logic [SW-1:0] r_speed, n_speed;

    // unit hookup
    logic [MUL_W-1:0] w_mul_a, w_mul_b;
    logic [PROD_W-1:0] w_prod;
    t_div_ctl w_div_ctl;
    t_unit_sts w_div_sts, w_sq_sts;
    logic [DIV_W-1:0] w_div_rem, w_div_bits, w_div_den, w_quo, w_sq_val;
    logic w_sq_start;
    logic [ROOT_W-1:0] w_root;

    // helpers
    logic signed [CW-1:0] w_prev, w_cur, w_res_c;
    logic signed [MW-1:0] w_d;
    logic signed [MW:0] w_res;
    logic [MW-1:0] w_t;
    logic [MW+23:0] w_num;
    logic [24:0] w_num_hi;
    logic [CW-1:0] w_q;
    logic [DIV_W-1:0] w_n;
    logic [HW-1:0] w_hi;
    logic [64:0] w_term;
    logic [32:0] w_tot;

    function automatic logic signed [CW-1:0] sat_in(input logic signed [31:0] v);
        logic signed [EW-1:0] e;
        e = EW'(v);
        if (e > EW'(C_HI)) return C_HI;
        if (e < EW'(C_LO)) return C_LO;
        return CW'(e);
    endfunction

    function automatic logic [31:0] sat_out(input logic signed [CW-1:0] v);
        logic signed [EW-1:0] e;
        e = EW'(v);
        if (e > EW'(O_HI)) return O_HI;
        if (e < EW'(O_LO)) return O_LO;
        return 32'(e);
    endfunction

    function automatic logic [CW-1:0] mag_c(input logic signed [CW-1:0] v);
        return v[CW-1] ? CW'(-v) : CW'(v);
    endfunction

    oepf_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    oepf_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_div_ctl),
        .i_rem     (w_div_rem),
        .i_bits    (w_div_bits),
        .i_divisor (w_div_den),
        .o_sts     (w_div_sts),
        .o_quo     (w_quo)
    );

    oepf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_val   (w_sq_val),
        .o_sts   (w_sq_sts),
        .o_root  (w_root)
    );

    always_comb begin
        if (r_pass || r_state == S_RATE) begin
            w_prev = r_lane ? r_last_y : r_last_x;
            w_cur  = r_lane ? r_py : r_px;
        end else begin
            w_prev = r_lane ? r_rate_y : r_rate_x;
            w_cur  = r_raw;
        end
    end

    assign w_d      = MW'(w_cur) - MW'(w_prev);
    assign w_t      = MW'(r_acc + (w_prod >> 16));
    assign w_res    = r_neg ? (MW+1)'(w_prev) - $signed({1'b0, w_t})
                            : (MW+1)'(w_prev) + $signed({1'b0, w_t});
    assign w_res_c  = CW'(w_res);
    assign w_num    = {r_mag, 24'd0};
    assign w_num_hi = w_num[MW+23:CW];
    assign w_q      = w_quo[CW-1:0];
    assign w_n      = N_ONE + (r_acc >> 1);
    assign w_hi     = HW'(r_speed >> 16);
    assign w_term   = {1'b0, r_acc} + 65'(w_prod[63:16]);
    assign w_tot    = {1'b0, w_term[31:0]} + {1'b0, r_min_cut};

    always_comb begin
        n_state  = r_state;
        n_ph     = r_ph;
        n_lane   = r_lane;
        n_pass   = r_pass;
        n_seeded = r_seeded;
        n_last_x = r_last_x;
        n_last_y = r_last_y;
        n_rate_x = r_rate_x;
        n_rate_y = r_rate_y;
        n_px     = r_px;
        n_py     = r_py;
        n_raw    = r_raw;
        n_dt     = r_dt;
        n_fc     = r_fc;
        n_u      = r_u;
        n_acc    = r_acc;
        n_alpha  = r_alpha;
        n_mag    = r_mag;
        n_neg    = r_neg;
        n_sa     = r_sa;
        n_sb     = r_sb;
        n_s      = r_s;
        n_speed  = r_speed;
        n_ox     = r_ox;
        n_oy     = r_oy;
        n_ovalid = r_ovalid && i_out_stall;
        w_mul_a    = '0;
        w_mul_b    = '0;
        w_div_ctl  = '0;
        w_div_rem  = '0;
        w_div_bits = '0;
        w_div_den  = '0;
        w_sq_start = 1'b0;
        w_sq_val   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_cmd) begin
                        n_seeded = 1'b0;
                        n_last_x = '0;
                        n_last_y = '0;
                        n_rate_x = '0;
                        n_rate_y = '0;
                    end else begin
                        n_px = sat_in(i_x_in);
                        n_py = sat_in(i_y_in);
                        n_dt = (i_step_time > STEP_FLOOR) ? i_step_time : r_dstep;
                        n_ph = '0;
                        if (!r_seeded) begin
                            n_seeded = 1'b1;
                            n_last_x = sat_in(i_x_in);
                            n_last_y = sat_in(i_y_in);
                            n_rate_x = '0;
                            n_rate_y = '0;
                            n_state  = S_OUT;
                        end else begin
                            n_fc    = r_dcut;
                            n_pass  = 1'b0;
                            n_lane  = 1'b0;
                            n_state = S_ALPHA;
                        end
                    end
                end
            end

            S_ALPHA: begin
                unique case (r_ph)
                    3'd0: begin
                        if (r_fc == '0 || r_dt == '0) begin
                            n_alpha = ALPHA_ONE;
                            n_lane  = 1'b0;
                            n_state = r_pass ? S_BLEND : S_RATE;
                        end else begin
                            w_mul_a = MUL_W'(r_fc);
                            w_mul_b = MUL_W'(r_dt);
                            n_ph    = 3'd1;
                        end
                    end
                    3'd1: begin
                        n_u     = w_prod[63:0];
                        w_mul_a = MUL_W'(w_prod[63:32]);
                        w_mul_b = MUL_W'(TWO_PI_Q29);
                        n_ph    = 3'd2;
                    end
                    3'd2: begin
                        n_acc   = w_prod[63:0];
                        w_mul_a = MUL_W'(r_u[31:0]);
                        w_mul_b = MUL_W'(TWO_PI_Q29);
                        n_ph    = 3'd3;
                    end
                    3'd3: begin
                        n_acc = (r_acc >> 5)
                              + (((r_acc & 64'd31) + DIV_W'(w_prod[63:32])) >> 5);
                        n_ph  = 3'd4;
                    end
                    3'd4: begin
                        n_acc = ((r_acc > P_CAP) ? P_CAP : r_acc) + P_ONE;
                        n_ph  = 3'd5;
                    end
                    default: begin
                        w_div_ctl.start = 1'b1;
                        w_div_ctl.steps = CNT_W'(ALPHA_STEPS);
                        w_div_rem       = w_n >> ALPHA_STEPS;
                        w_div_bits      = DIV_W'(w_n[ALPHA_STEPS-1:0])
                                          << (DIV_W - ALPHA_STEPS);
                        w_div_den       = r_acc;
                        n_ph            = '0;
                        n_state         = S_ADIV;
                    end
                endcase
            end

            S_ADIV: begin
                if (w_div_sts.done) begin
                    n_alpha = ALPHA_ONE - w_quo[ALPHA_W-1:0];
                    n_lane  = 1'b0;
                    n_state = r_pass ? S_BLEND : S_RATE;
                end
            end

            S_RATE: begin
                if (r_ph == '0) begin
                    n_neg = w_d[MW-1];
                    n_mag = w_d[MW-1] ? MW'(-w_d) : MW'(w_d);
                    if (r_dt == '0) begin
                        n_raw   = '0;
                        n_state = S_BLEND;
                    end else begin
                        n_ph = 3'd1;
                    end
                end else begin
                    n_ph = '0;
                    if (32'(w_num_hi) >= r_dt) begin
                        n_raw   = r_neg ? C_LO : C_HI;
                        n_state = S_BLEND;
                    end else begin
                        w_div_ctl.start = 1'b1;
                        w_div_ctl.steps = CNT_W'(CW);
                        w_div_rem       = DIV_W'(w_num_hi);
                        w_div_bits      = DIV_W'(w_num[CW-1:0]) << (DIV_W - CW);
                        w_div_den       = DIV_W'(r_dt);
                        n_state         = S_RDIV;
                    end
                end
            end

            S_RDIV: begin
                if (w_div_sts.done) begin
                    if (r_neg) begin
                        n_raw = (w_q > C_HALF) ? C_LO : -$signed(w_q);
                    end else begin
                        n_raw = w_q[CW-1] ? C_HI : $signed(w_q);
                    end
                    n_state = S_BLEND;
                end
            end

            S_BLEND: begin
                unique case (r_ph)
                    3'd0: begin
                        n_neg = w_d[MW-1];
                        n_mag = w_d[MW-1] ? MW'(-w_d) : MW'(w_d);
                        n_ph  = 3'd1;
                    end
                    3'd1: begin
                        w_mul_a = MUL_W'(r_mag >> 16);
                        w_mul_b = MUL_W'(r_alpha);
                        n_ph    = 3'd2;
                    end
                    3'd2: begin
                        n_acc   = w_prod[63:0];
                        w_mul_a = MUL_W'(r_mag[15:0]);
                        w_mul_b = MUL_W'(r_alpha);
                        n_ph    = 3'd3;
                    end
                    default: begin
                        n_ph = '0;
                        priority case ({r_pass, r_lane})
                            2'b00: n_rate_x = w_res_c;
                            2'b01: n_rate_y = w_res_c;
                            2'b10: n_last_x = w_res_c;
                            default: n_last_y = w_res_c;
                        endcase
                        if (!r_lane) begin
                            n_lane  = 1'b1;
                            n_state = r_pass ? S_BLEND : S_RATE;
                        end else begin
                            n_lane  = 1'b0;
                            n_state = r_pass ? S_OUT : S_SHIFT;
                        end
                    end
                endcase
            end

            S_SHIFT: begin
                if (r_ph == '0) begin
                    n_sa = mag_c(r_rate_x);
                    n_sb = mag_c(r_rate_y);
                    n_s  = '0;
                    n_ph = 3'd1;
                end else if ((r_sa >> 31) != '0 || (r_sb >> 31) != '0) begin
                    n_sa = r_sa >> 1;
                    n_sb = r_sb >> 1;
                    n_s  = r_s + 1'b1;
                end else begin
                    n_ph    = '0;
                    n_state = S_SQ;
                end
            end

            S_SQ: begin
                unique case (r_ph)
                    3'd0: begin
                        w_mul_a = MUL_W'(r_sa);
                        w_mul_b = MUL_W'(r_sa);
                        n_ph    = 3'd1;
                    end
                    3'd1: begin
                        n_acc   = w_prod[63:0];
                        w_mul_a = MUL_W'(r_sb);
                        w_mul_b = MUL_W'(r_sb);
                        n_ph    = 3'd2;
                    end
                    default: begin
                        w_sq_start = 1'b1;
                        w_sq_val   = r_acc + w_prod[63:0];
                        n_ph       = '0;
                        n_state    = S_SQRT;
                    end
                endcase
            end

            S_SQRT: begin
                if (w_sq_sts.done) begin
                    n_speed = SW'(w_root) << r_s;
                    n_state = S_CUT;
                end
            end

            S_CUT: begin
                unique case (r_ph)
                    3'd0: begin
                        if (r_beta == '0) begin
                            n_fc    = r_min_cut;
                            n_pass  = 1'b1;
                            n_state = S_ALPHA;
                        end else if ((w_hi >> 32) != '0) begin
                            n_fc    = '1;
                            n_pass  = 1'b1;
                            n_state = S_ALPHA;
                        end else begin
                            w_mul_a = MUL_W'(r_beta);
                            w_mul_b = MUL_W'(w_hi);
                            n_ph    = 3'd1;
                        end
                    end
                    3'd1: begin
                        n_acc   = w_prod[63:0];
                        w_mul_a = MUL_W'(r_beta);
                        w_mul_b = MUL_W'(r_speed[15:0]);
                        n_ph    = 3'd2;
                    end
                    default: begin
                        if (w_term[64:32] != '0) begin
                            n_fc = '1;
                        end else begin
                            n_fc = w_tot[32] ? '1 : w_tot[31:0];
                        end
                        n_ph    = '0;
                        n_pass  = 1'b1;
                        n_state = S_ALPHA;
                    end
                endcase
            end

            S_OUT: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ox     = sat_out(r_last_x);
                    n_oy     = sat_out(r_last_y);
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ph      <= '0;
            r_lane    <= 1'b0;
            r_pass    <= 1'b0;
            r_seeded  <= 1'b0;
            r_ovalid  <= 1'b0;
            r_last_x  <= '0;
            r_last_y  <= '0;
            r_rate_x  <= '0;
            r_rate_y  <= '0;
            r_min_cut <= MIN_CUT_RST;
            r_beta    <= BETA_RST;
            r_dcut    <= DCUT_RST;
            r_dstep   <= STEP_RST;
        end else begin
            r_state  <= n_state;
            r_ph     <= n_ph;
            r_lane   <= n_lane;
            r_pass   <= n_pass;
            r_seeded <= n_seeded;
            r_ovalid <= n_ovalid;
            r_last_x <= n_last_x;
            r_last_y <= n_last_y;
            r_rate_x <= n_rate_x;
            r_rate_y <= n_rate_y;
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_idx))
                    REG_MIN_CUTOFF:   if (i_cfg_data != '0) r_min_cut <= i_cfg_data;
                    REG_BETA_GAIN:    r_beta <= i_cfg_data;
                    REG_DERIV_CUTOFF: if (i_cfg_data != '0) r_dcut <= i_cfg_data;
                    REG_DEFAULT_STEP: r_dstep <= i_cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_px    <= n_px;
        r_py    <= n_py;
        r_raw   <= n_raw;
        r_dt    <= n_dt;
        r_fc    <= n_fc;
        r_u     <= n_u;
        r_acc   <= n_acc;
        r_alpha <= n_alpha;
        r_mag   <= n_mag;
        r_neg   <= n_neg;
        r_sa    <= n_sa;
        r_sb    <= n_sb;
        r_s     <= n_s;
        r_speed <= n_speed;
        r_ox    <= n_ox;
        r_oy    <= n_oy;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_x_out     = r_ox;
    assign o_y_out     = r_oy;

endmodule

`default_nettype wire

// ===== hw/rtl/oepf_mul.sv =====
// ----------------------------------------------------------------------------
// oepf_mul
// Shared unsigned multiplier with a registered product, one result a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module oepf_mul import oepf_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic [MUL_W-1:0]  i_a,
    input  wire logic [MUL_W-1:0]  i_b,
    output logic      [PROD_W-1:0] o_prod
);

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ===== hw/rtl/oepf_div.sv =====
// ----------------------------------------------------------------------------
// oepf_div
// Restoring divider, one quotient bit a cycle. The caller preloads the
// partial remainder (below the divisor) and left-aligned numerator bits.
// ----------------------------------------------------------------------------
`default_nettype none

module oepf_div import oepf_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_div_ctl         i_ctl,
    input  wire logic [DIV_W-1:0] i_rem,
    input  wire logic [DIV_W-1:0] i_bits,
    input  wire logic [DIV_W-1:0] i_divisor,
    output t_unit_sts             o_sts,
    output logic      [DIV_W-1:0] o_quo
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_bits;
    logic [DIV_W-1:0] r_div;
    logic [DIV_W-1:0] r_quo;
    logic [DIV_W-1:0] n_trial;
    logic             n_ge;

    assign n_trial = {r_rem[DIV_W-2:0], r_bits[DIV_W-1]};
    assign n_ge    = n_trial >= r_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem  <= i_rem;
            r_bits <= i_bits;
            r_div  <= i_divisor;
            r_quo  <= '0;
        end else if (r_busy) begin
            r_rem  <= n_ge ? n_trial - r_div : n_trial;
            r_bits <= r_bits << 1;
            r_quo  <= {r_quo[DIV_W-2:0], n_ge};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quo      = r_quo;

endmodule

`default_nettype wire

// ===== hw/rtl/oepf_sqrt.sv =====
// ----------------------------------------------------------------------------
// oepf_sqrt
// Integer square root of a 64-bit value, rounded down, one root bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module oepf_sqrt import oepf_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIV_W-1:0]  i_val,
    output t_unit_sts              o_sts,
    output logic      [ROOT_W-1:0] o_root
);

    localparam int SC_W = $clog2(SQ_STEPS);

    logic             r_busy;
    logic             r_done;
    logic [SC_W-1:0]  r_cnt;
    logic [DIV_W-1:0] r_v;
    logic [DIV_W-1:0] r_res;
    logic [DIV_W-1:0] r_bit;
    logic [DIV_W-1:0] n_try;
    logic             n_ge;

    assign n_try = r_res + r_bit;
    assign n_ge  = r_v >= n_try;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= SC_W'(SQ_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_val;
            r_res <= '0;
            r_bit <= SQ_TOP_BIT;
        end else if (r_busy) begin
            r_v   <= n_ge ? r_v - n_try : r_v;
            r_res <= n_ge ? (r_res >> 1) + r_bit : r_res >> 1;
            r_bit <= r_bit >> 2;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_root     = r_res[ROOT_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/oepf_chk.sv =====
// ----------------------------------------------------------------------------
// oepf_chk
// Port-level checks of the point filter, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module oepf_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        i_cmd,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [31:0] o_x_out,
    input wire logic [31:0] o_y_out
);

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_busy_after_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !i_cmd) |=> o_in_stall)
        else $error("input taken while a sample is in work");

    a_clear_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_cmd) |=> !o_in_stall)
        else $error("clear transaction blocked the input");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_x_out) && $stable(o_y_out)))
        else $error("stalled result changed");

endmodule

bind one_euro_point_filter_top oepf_chk u_oepf_chk (.*);

`default_nettype wire

// ===== sim/one_euro_point_filter_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// one_euro_point_filter_top_tb
// Self-checking bench for the one euro point filter. A scoreboard predicts
// every smoothed point from the accepted samples and the register settings,
// and compares each output transaction field by field. Directed samples
// cover extremes, clears and the default time step; random walks with noise
// follow under several register settings and idling patterns.
// ----------------------------------------------------------------------------

module one_euro_point_filter_top_tb;
    import oepf_pkg::*;

    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int SETTLE       = 250;
    localparam int HOLD_CYCLES  = 3000;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
    } point_t;

    class euro_filter_check;
        int unsigned min_cut, beta, dcut, dstep;
        bit          seeded;
        longint      last_x, last_y, rate_x, rate_y;
        point_t      expected_points[$];
        int          errors;

        function new();
            min_cut = 65536;
            beta    = 0;
            dcut    = 65536;
            dstep   = 559241;
            errors  = 0;
            clear_state();
        endfunction

        function void clear_state();
            seeded = 0;
            last_x = 0;
            last_y = 0;
            rate_x = 0;
            rate_y = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] v);
            case (idx)
                REG_MIN_CUTOFF:   if (v != 0) min_cut = v;
                REG_BETA_GAIN:    beta = v;
                REG_DERIV_CUTOFF: if (v != 0) dcut = v;
                REG_DEFAULT_STEP: dstep = v;
            endcase
        endfunction

        function longint unsigned mag(longint v);
            return v < 0 ? 64'(-v) : 64'(v);
        endfunction

        function longint raw_rate(longint d, int unsigned dt);
            longint unsigned cap, m, q, r, res;
            if (dt == 0) return 0;
            cap = 64'h7FFF_FFFF + (d < 0 ? 1 : 0);
            m = mag(d);
            q = m / dt;
            r = m % dt;
            if (q > (cap >> 24)) res = cap;
            else res = (q << 24) + ((r << 24) / dt);
            if (res > cap) res = cap;
            return d < 0 ? -longint'(res) : longint'(res);
        endfunction

        function longint lowpass(longint prev, longint cur, int unsigned a);
            longint          d;
            longint unsigned m, t;
            d = cur - prev;
            m = mag(d);
            t = (m >> 16) * a + (((m & 64'hFFFF) * a) >> 16);
            return d < 0 ? prev - longint'(t) : prev + longint'(t);
        endfunction

        function int unsigned alpha_of(int unsigned fc, int unsigned dt);
            longint unsigned u, a_hi, b_lo, p, den, c;
            if (fc == 0 || dt == 0) return 65536;
            u = 64'(fc) * 64'(dt);
            a_hi = (u >> 32) * 64'(TWO_PI_Q29);
            b_lo = (u & 64'hFFFF_FFFF) * 64'(TWO_PI_Q29);
            p = (a_hi >> 5) + (((a_hi & 31) + (b_lo >> 32)) >> 5);
            if (p > P_CAP) p = P_CAP;
            den = p + P_ONE;
            c = (N_ONE + den / 2) / den;
            return 32'(65536 - c);
        endfunction

        function longint unsigned root64(longint unsigned v);
            longint unsigned res, b;
            res = 0;
            b = SQ_TOP_BIT;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        function longint unsigned speed_of(longint rx, longint ry);
            longint unsigned ax, ay, m, a, b;
            int              s;
            ax = mag(rx);
            ay = mag(ry);
            m = ax > ay ? ax : ay;
            s = 0;
            while ((m >> s) >= 64'h8000_0000) s++;
            a = ax >> s;
            b = ay >> s;
            return root64(a * a + b * b) << s;
        endfunction

        function int unsigned cutoff_of(longint unsigned spd);
            longint unsigned hi, lo, term, total;
            hi = spd >> 16;
            lo = spd & 64'hFFFF;
            if (beta == 0) term = 0;
            else if (hi > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
            else term = 64'(beta) * hi + ((64'(beta) * lo) >> 16);
            if (term > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
            total = term + min_cut;
            return total > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : 32'(total);
        endfunction

        function void note_sample(logic cmd, logic [31:0] xi, logic [31:0] yi,
                                  logic [31:0] st);
            longint      px, py;
            int unsigned dt, a;
            point_t      pt;
            if (cmd) begin
                clear_state();
                return;
            end
            px = longint'($signed(xi));
            py = longint'($signed(yi));
            dt = st > STEP_FLOOR ? st : dstep;
            if (!seeded) begin
                seeded = 1;
                last_x = px;
                last_y = py;
                rate_x = 0;
                rate_y = 0;
            end else begin
                a = alpha_of(dcut, dt);
                rate_x = lowpass(rate_x, raw_rate(px - last_x, dt), a);
                rate_y = lowpass(rate_y, raw_rate(py - last_y, dt), a);
                a = alpha_of(cutoff_of(speed_of(rate_x, rate_y)), dt);
                last_x = lowpass(last_x, px, a);
                last_y = lowpass(last_y, py, a);
            end
            pt.x = 32'(last_x);
            pt.y = 32'(last_y);
            expected_points.push_back(pt);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("MISMATCH %s: got %h expected %h", what, got, want);
            errors++;
        endtask

        task check_point(logic [31:0] xo, logic [31:0] yo);
            point_t pt;
            if (expected_points.size() == 0) begin
                report("unexpected point", xo, yo);
                return;
            end
            pt = expected_points.pop_front();
            if (xo !== pt.x) report("x_out", xo, pt.x);
            if (yo !== pt.y) report("y_out", yo, pt.y);
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        o_in_stall;
    logic        i_cmd = 0;
    logic [31:0] i_x_in = 0;
    logic [31:0] i_y_in = 0;
    logic [31:0] i_step_time = 0;
    logic        o_out_valid;
    logic        i_out_stall = 0;
    logic [31:0] o_x_out;
    logic [31:0] o_y_out;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_idx = 0;
    logic [31:0] i_cfg_data = 0;

    euro_filter_check sb = new();
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    bit     hold_req = 0;
    int     hold_cnt = 0;
    int     cycles = 0;
    longint walk_x = 0, walk_y = 0;

    one_euro_point_filter_top u_dut (.*);

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: check, then pick the stall for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_point(o_x_out, o_y_out);
        if (hold_req) begin
            i_out_stall <= 1'b1;
            hold_cnt = hold_cnt + 1;
            if (hold_cnt >= HOLD_CYCLES) begin
                hold_req = 0;
                hold_cnt = 0;
            end
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task send_sample(logic cmd, logic [31:0] xi, logic [31:0] yi, logic [31:0] st);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_cmd       <= cmd;
        i_x_in      <= xi;
        i_y_in      <= yi;
        i_step_time <= st;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_sample(cmd, xi, yi, st);
    endtask

    task drain_and_settle();
        i_in_valid <= 1'b0;
        while (sb.expected_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task cfg_write(t_reg_idx idx, logic [31:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.set_reg(idx, v);
    endtask

    task program_filter(logic [31:0] mc, logic [31:0] bg, logic [31:0] dc,
                        logic [31:0] ds);
        cfg_write(REG_MIN_CUTOFF, mc);
        cfg_write(REG_BETA_GAIN, bg);
        cfg_write(REG_DERIV_CUTOFF, dc);
        cfg_write(REG_DEFAULT_STEP, ds);
        i_cfg_we <= 1'b0;
    endtask

    function logic [31:0] pick_step();
        case ($urandom_range(9))
            0: return $urandom_range(16);
            1: return $urandom;
            2: return $urandom_range(17, 4000);
            default: return $urandom_range(17, 2_000_000);
        endcase
    endfunction

    function longint clamp32(longint v);
        if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) return -64'sh8000_0000;
        return v;
    endfunction

    task run_walk(int n);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 4) begin
                send_sample(1'b1, $urandom, $urandom, $urandom);
            end else if (r < 12) begin
                send_sample(1'b0, $urandom, $urandom, $urandom);
            end else begin
                if (r < 15) begin
                    walk_x = $urandom_range(1) ? 64'sh7FFF_FFFF : -64'sh8000_0000;
                    walk_y = longint'($signed(32'($urandom)));
                end
                walk_x = clamp32(walk_x + ($signed(32'($urandom)) >>> $urandom_range(8, 30)));
                walk_y = clamp32(walk_y + ($signed(32'($urandom)) >>> $urandom_range(8, 30)));
                send_sample(1'b0, 32'(walk_x), 32'(walk_y), pick_step());
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, default step, clears
        send_sample(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
        send_sample(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd16);
        send_sample(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd17);
        send_sample(1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_sample(1'b0, 32'h0001_0000, 32'h0001_0000, 32'd559241);
        send_sample(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_sample(1'b1, 32'h0, 32'h0, 32'h0);
        send_sample(1'b0, 32'h8000_0000, 32'h8000_0000, 32'd1);
        send_sample(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1);
        send_sample(1'b0, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
        send_sample(1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0011);
        send_sample(1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0100_0000);
        send_sample(1'b0, 32'h0010_0000, 32'hFFF0_0000, 32'h0008_8889);
        send_sample(1'b1, 32'h0, 32'h0, 32'h0);
        send_sample(1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        send_sample(1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        send_sample(1'b0, 32'hFFFF_FFFF, 32'h0000_0001, 32'd8);
        send_sample(1'b0, 32'h0000_0001, 32'hFFFF_FFFF, 32'd0);

        for (int ph = 0; ph < 6; ph++) begin
            drain_and_settle();
            case (ph)
                1: program_filter(32'd1, 32'hFFFF_FFFF, 32'd1, 32'd17);
                2: program_filter(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                3: program_filter(32'd0, 32'd131072, 32'd0, 32'd0);
                4: program_filter(32'd196608, 32'h0000_8000, 32'd327680, 32'd559241);
                5: program_filter($urandom_range(1, 32'hFFFF_FFFF), $urandom,
                                  $urandom_range(1, 32'hFFFF_FFFF),
                                  $urandom_range(17, 4_000_000));
                default: ;
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            if (ph == 2) hold_req = 1;
            run_walk(160);
            if (ph == 3) begin
                i_in_valid <= 1'b0;
                while (sb.expected_points.size() != 0) @(posedge i_clk);
                @(posedge i_clk);
            end
            run_walk(160);
        end

        drain_and_settle();
        while (sb.expected_points.size() != 0) begin
            sb.report("missing point", 32'h0, sb.expected_points[0].x);
            void'(sb.expected_points.pop_front());
        end
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
